>>> rtl/encoder_sample_statistics_defines.svh
`ifndef ENCODER_SAMPLE_STATISTICS_DEFINES_SVH
`define ENCODER_SAMPLE_STATISTICS_DEFINES_SVH

// Concurrent check, sampled on clk and quiet while reset is held
`define ESS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition on one edge implies another on the next edge
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
  `ESS_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/ess_pkg.sv
`timescale 1ns / 1ps
package ess_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic signed [63:0] SQUARE_LIMIT     = 64'sd3037000499;
  localparam logic signed [63:0] NEG_SQUARE_LIMIT = -64'sd3037000499;

  // Q16 scaling of the mean (times 65536)
  localparam int Q16_SHIFT = 16;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FAIL   = 2'd2
  } status_t;

  localparam logic [3:0] WORD_COUNT   = 4'd0;
  localparam logic [3:0] WORD_FIRST   = 4'd1;
  localparam logic [3:0] WORD_LAST    = 4'd2;
  localparam logic [3:0] WORD_MIN     = 4'd3;
  localparam logic [3:0] WORD_MAX     = 4'd4;
  localparam logic [3:0] WORD_SUM     = 4'd5;
  localparam logic [3:0] WORD_SUMSQ   = 4'd6;
  localparam logic [3:0] WORD_MAXSTEP = 4'd7;
  localparam logic [3:0] WORD_CRC     = 4'd8;
  localparam logic [3:0] WORD_P2P     = 4'd9;
  localparam logic [3:0] WORD_DRIFT   = 4'd10;
  localparam logic [3:0] WORD_MEAN    = 4'd11;

  // Request to and response from the shared 64-bit adder
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        ovf;
    logic        neg;
  } alu_rsp_t;

endpackage

>>> rtl/ess_if.sv
`timescale 1ns / 1ps
interface ess_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] raw_sample;

  modport source (output valid, cmd, raw_sample, input ready);
  modport sink (input valid, cmd, raw_sample, output ready);
endinterface

interface ess_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         word_index;
  logic signed [63:0] word_value;
  logic               last;

  modport source (output valid, status, word_index, word_value, last, input ready);
  modport sink (input valid, status, word_index, word_value, last, output ready);
endinterface

>>> rtl/ess_alu.sv
`timescale 1ns / 1ps
module ess_alu (
  input  ess_pkg::alu_req_t req_i,
  output ess_pkg::alu_rsp_t rsp_o
);
  import ess_pkg::*;

  logic [64:0] a_ext;
  logic [64:0] b_ext;
  logic [64:0] res;

  // Add or subtract with one guard bit for signed overflow
  always_comb begin
    a_ext = {req_i.a[63], req_i.a};
    b_ext = {req_i.b[63], req_i.b};
    res   = req_i.sub ? (a_ext - b_ext) : (a_ext + b_ext);
    rsp_o.sum = res[63:0];
    rsp_o.ovf = res[64] ^ res[63];
    rsp_o.neg = res[64];
  end
endmodule

>>> rtl/ess_crc.sv
`timescale 1ns / 1ps
module ess_crc (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);
  import ess_pkg::*;

  logic [31:0] c;

  // Absorb one byte, reflected, low bit first
  always_comb begin
    c = crc_i ^ {24'd0, byte_i};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end
endmodule

>>> rtl/encoder_sample_statistics.sv
`timescale 1ns / 1ps
// Running statistics over 16-bit encoder samples.
// in_ch carries cmd and raw_sample: push a sample, clear the statistics or
// ask for a report. out_ch returns status, word_index, word_value and last.
// Beats move when valid and ready are both high.
// A push makes, between acceptance and its one result beat, four passes
// through the shared 64-bit adder, one 32x32 square and two CRC byte steps.
// The first sample after reset or clear skips the adder passes and the
// square, a push rejected on overflow skips the CRC steps, and a push
// refused on a full count goes straight to its beat. A clear also goes
// straight to its beat; cmd 3 is dropped at once. Before its first word a
// report makes four adder passes (peak-to-peak, drift, scaled magnitude,
// rounding half), then a restoring divide of 64 steps on the same adder,
// then the sign fix; the twelve words then follow one per cycle while
// out_ch.ready is high. A failed report gives a single beat with status 2.
// in_ch.ready is high only while the sequencer is idle, one item at a time.
// Results sit in an output register; when out_ch.ready is low the beat holds
// and the sequencer waits for the slot to free.
// Reset (rst_n low, synchronous) empties the output register, idles the
// sequencer and returns the statistics to zero with the CRC at all ones.
module encoder_sample_statistics #(
  parameter int COUNT_WIDTH = ess_pkg::COUNT_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ess_in_if.sink   in_ch,
  ess_out_if.source out_ch
);
  import ess_pkg::*;

  localparam int CW = COUNT_WIDTH;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PUSH  = 16'h0002,
    S_NU    = 16'h0004,
    S_REL   = 16'h0008,
    S_SUM   = 16'h0010,
    S_MUL   = 16'h0020,
    S_SQ    = 16'h0040,
    S_CRC0  = 16'h0080,
    S_CRC1  = 16'h0100,
    S_P2P   = 16'h0200,
    S_DRIFT = 16'h0400,
    S_MAG   = 16'h0800,
    S_HALF  = 16'h1000,
    S_DIV   = 16'h2000,
    S_SIGN  = 16'h4000,
    S_EMIT  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // Statistics
  logic                started_r, started_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [15:0]         first_r, first_nxt;
  logic [15:0]         lastraw_r, lastraw_nxt;
  logic signed [63:0]  lu_r, lu_nxt;
  logic signed [63:0]  min_r, min_nxt;
  logic signed [63:0]  max_r, max_nxt;
  logic signed [63:0]  sum_r, sum_nxt;
  logic signed [63:0]  sumsq_r, sumsq_nxt;
  logic [15:0]         maxstep_r, maxstep_nxt;
  logic [31:0]         crc_r, crc_nxt;

  // Working registers
  logic [15:0]         raw_r, raw_nxt;
  logic signed [63:0]  nu_r, nu_nxt;
  logic signed [63:0]  rel_r, rel_nxt;
  logic signed [63:0]  ns_r, ns_nxt;
  logic [31:0]         abs_r, abs_nxt;
  logic [63:0]         sq_r, sq_nxt;
  logic signed [63:0]  p2p_r, p2p_nxt;
  logic signed [63:0]  drift_r, drift_nxt;
  logic signed [63:0]  mean_r, mean_nxt;
  logic [63:0]         quo_r, quo_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [5:0]          div_cnt_r, div_cnt_nxt;
  logic                err_r, err_nxt;
  logic                neg_r, neg_nxt;
  logic                rep_r, rep_nxt;
  status_t             stat_r, stat_nxt;
  logic [3:0]          word_r, word_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [3:0]          out_index_r, out_index_nxt;
  logic signed [63:0]  out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic [7:0]          crc_byte;
  logic [31:0]         crc_step;
  logic [15:0]         delta;
  logic [15:0]         step_abs;
  logic [CW:0]         trial;
  logic                emit_free;
  logic signed [63:0]  word_val;

  ess_alu u_alu (.req_i(alu_req), .rsp_o(alu_rsp));
  ess_crc u_crc (.crc_i(crc_r), .byte_i(crc_byte), .crc_o(crc_step));

  assign delta    = raw_r - lastraw_r;
  assign step_abs = delta[15] ? (16'd0 - delta) : delta;
  assign trial    = {rem_r, quo_r[63]};
  assign crc_byte = (state_r == S_CRC1) ? raw_r[15:8] : raw_r[7:0];
  assign emit_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.word_index = out_index_r;
  assign out_ch.word_value = out_value_r;
  assign out_ch.last       = out_last_r;

  // Select operands for the shared adder
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_NU:    alu_req = '{a: lu_r, b: {{48{delta[15]}}, delta}, sub: 1'b0};
      S_REL:   alu_req = '{a: nu_r, b: {48'd0, first_r}, sub: 1'b1};
      S_SUM:   alu_req = '{a: sum_r, b: rel_r, sub: 1'b0};
      S_SQ:    alu_req = '{a: sumsq_r, b: sq_r, sub: 1'b0};
      S_P2P:   alu_req = '{a: max_r, b: min_r, sub: 1'b1};
      S_DRIFT: alu_req = '{a: lu_r, b: {48'd0, first_r}, sub: 1'b1};
      S_MAG:   alu_req = '{a: 64'd0, b: {sum_r[63-Q16_SHIFT:0], {Q16_SHIFT{1'b0}}},
                           sub: sum_r[63]};
      S_HALF:  alu_req = '{a: quo_r, b: {{(65-CW){1'b0}}, count_r[CW-1:1]}, sub: 1'b0};
      S_DIV:   alu_req = '{a: {{(63-CW){1'b0}}, trial}, b: {{(64-CW){1'b0}}, count_r},
                           sub: 1'b1};
      S_SIGN:  alu_req = '{a: 64'd0, b: quo_r, sub: neg_r};
      default: alu_req = '0;
    endcase
  end

  // Pick the report word
  always_comb begin
    case (word_r)
      WORD_COUNT:   word_val = {{(64-CW){1'b0}}, count_r};
      WORD_FIRST:   word_val = {48'd0, first_r};
      WORD_LAST:    word_val = {48'd0, lastraw_r};
      WORD_MIN:     word_val = min_r;
      WORD_MAX:     word_val = max_r;
      WORD_SUM:     word_val = sum_r;
      WORD_SUMSQ:   word_val = sumsq_r;
      WORD_MAXSTEP: word_val = {48'd0, maxstep_r};
      WORD_CRC:     word_val = {32'd0, crc_r ^ CRC_INIT};
      WORD_P2P:     word_val = p2p_r;
      WORD_DRIFT:   word_val = drift_r;
      default:      word_val = mean_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    count_nxt   = count_r;
    first_nxt   = first_r;
    lastraw_nxt = lastraw_r;
    lu_nxt      = lu_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    sum_nxt     = sum_r;
    sumsq_nxt   = sumsq_r;
    maxstep_nxt = maxstep_r;
    crc_nxt     = crc_r;
    raw_nxt     = raw_r;
    nu_nxt      = nu_r;
    rel_nxt     = rel_r;
    ns_nxt      = ns_r;
    abs_nxt     = abs_r;
    sq_nxt      = sq_r;
    p2p_nxt     = p2p_r;
    drift_nxt   = drift_r;
    mean_nxt    = mean_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    err_nxt     = err_r;
    neg_nxt     = neg_r;
    rep_nxt     = rep_r;
    stat_nxt    = stat_r;
    word_nxt    = word_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          raw_nxt  = in_ch.raw_sample;
          err_nxt  = 1'b0;
          stat_nxt = ST_OK;
          word_nxt = WORD_COUNT;
          rep_nxt  = 1'b0;
          case (in_ch.cmd)
            CMD_PUSH: state_nxt = S_PUSH;
            CMD_CLEAR: begin
              started_nxt = 1'b0;
              count_nxt   = '0;
              first_nxt   = '0;
              lastraw_nxt = '0;
              lu_nxt      = '0;
              min_nxt     = '0;
              max_nxt     = '0;
              sum_nxt     = '0;
              sumsq_nxt   = '0;
              maxstep_nxt = '0;
              crc_nxt     = CRC_INIT;
              state_nxt   = S_EMIT;
            end
            CMD_REPORT: begin
              rep_nxt   = 1'b1;
              state_nxt = S_P2P;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (count_r == {CW{1'b1}}) begin
          stat_nxt  = ST_REJECT;
          state_nxt = S_EMIT;
        end else if (!started_r) begin
          started_nxt = 1'b1;
          count_nxt   = {{(CW-1){1'b0}}, 1'b1};
          first_nxt   = raw_r;
          lastraw_nxt = raw_r;
          lu_nxt      = {48'd0, raw_r};
          min_nxt     = '0;
          max_nxt     = '0;
          sum_nxt     = '0;
          sumsq_nxt   = '0;
          maxstep_nxt = '0;
          state_nxt   = S_CRC0;
        end else begin
          state_nxt = S_NU;
        end
      end
      S_NU: begin
        nu_nxt    = alu_rsp.sum;
        err_nxt   = err_r | alu_rsp.ovf;
        state_nxt = S_REL;
      end
      S_REL: begin
        rel_nxt   = alu_rsp.sum;
        err_nxt   = err_r | alu_rsp.ovf;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ns_nxt    = alu_rsp.sum;
        err_nxt   = err_r | alu_rsp.ovf | (rel_r > SQUARE_LIMIT) |
                    (rel_r < NEG_SQUARE_LIMIT);
        abs_nxt   = rel_r[63] ? (~rel_r[31:0] + 32'd1) : rel_r[31:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        sq_nxt    = abs_r * abs_r;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (err_r || alu_rsp.ovf) begin
          stat_nxt  = ST_REJECT;
          state_nxt = S_EMIT;
        end else begin
          count_nxt   = count_r + {{(CW-1){1'b0}}, 1'b1};
          lastraw_nxt = raw_r;
          lu_nxt      = nu_r;
          if (rel_r < min_r) min_nxt = rel_r;
          if (rel_r > max_r) max_nxt = rel_r;
          sum_nxt     = ns_r;
          sumsq_nxt   = alu_rsp.sum;
          if (step_abs > maxstep_r) maxstep_nxt = step_abs;
          state_nxt   = S_CRC0;
        end
      end
      S_CRC0: begin
        crc_nxt   = crc_step;
        state_nxt = S_CRC1;
      end
      S_CRC1: begin
        crc_nxt   = crc_step;
        state_nxt = S_EMIT;
      end
      S_P2P: begin
        p2p_nxt   = alu_rsp.sum;
        err_nxt   = !started_r | alu_rsp.ovf;
        state_nxt = S_DRIFT;
      end
      S_DRIFT: begin
        drift_nxt = alu_rsp.sum;
        err_nxt   = err_r | alu_rsp.ovf;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        // Scaled sum must fit; the most negative value has no magnitude
        quo_nxt   = alu_rsp.sum;
        neg_nxt   = sum_r[63];
        err_nxt   = err_r |
                    !((sum_r[63:47] == '0) ||
                      ((sum_r[63:47] == '1) && (sum_r[46:0] != '0)));
        state_nxt = S_HALF;
      end
      S_HALF: begin
        quo_nxt     = alu_rsp.sum;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        // Fail on an earlier error or when adding the rounding half leaves the signed range
        if (err_r || alu_rsp.ovf) begin
          stat_nxt  = ST_FAIL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One restoring divide step per cycle
        rem_nxt     = alu_rsp.neg ? trial[CW-1:0] : alu_rsp.sum[CW-1:0];
        quo_nxt     = {quo_r[62:0], !alu_rsp.neg};
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd63) state_nxt = S_SIGN;
      end
      S_SIGN: begin
        mean_nxt  = alu_rsp.sum;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          if (rep_r && stat_r == ST_OK) begin
            out_index_nxt = word_r;
            out_value_nxt = word_val;
            out_last_nxt  = (word_r == WORD_MEAN);
            word_nxt      = word_r + 4'd1;
            if (word_r == WORD_MEAN) state_nxt = S_IDLE;
          end else begin
            out_index_nxt = WORD_COUNT;
            out_value_nxt = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      count_r     <= '0;
      first_r     <= '0;
      lastraw_r   <= '0;
      lu_r        <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      maxstep_r   <= '0;
      crc_r       <= CRC_INIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      lastraw_r   <= lastraw_nxt;
      lu_r        <= lu_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      maxstep_r   <= maxstep_nxt;
      crc_r       <= crc_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    nu_r         <= nu_nxt;
    rel_r        <= rel_nxt;
    ns_r         <= ns_nxt;
    abs_r        <= abs_nxt;
    sq_r         <= sq_nxt;
    p2p_r        <= p2p_nxt;
    drift_r      <= drift_nxt;
    mean_r       <= mean_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    err_r        <= err_nxt;
    neg_r        <= neg_nxt;
    rep_r        <= rep_nxt;
    stat_r       <= stat_nxt;
    word_r       <= word_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end
endmodule

>>> rtl/ess_checker.sv
`timescale 1ns / 1ps
`include "encoder_sample_statistics_defines.svh"
module ess_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [3:0]  out_word_index,
  input logic [63:0] out_word_value,
  input logic        out_last
);
  import ess_pkg::*;

  // A rejected push or failed report is one beat carrying no word
  `ESS_ASSERT(a_fail_single, out_valid && (out_status != ST_OK) |-> out_last && (out_word_index == WORD_COUNT) && (out_word_value == 64'd0), "non-ok result is not a lone empty beat")

  // No new item is taken while a report is still streaming out
  `ESS_ASSERT(a_busy_in_report, out_valid && !out_last |-> !in_ready, "input taken in the middle of a report")

  // Only the mean word closes a report
  `ESS_ASSERT(a_report_end, out_valid && (out_status == ST_OK) && (out_word_index != WORD_COUNT) |-> (out_last == (out_word_index == WORD_MEAN)), "report closed on the wrong word")

  // Hold a stalled beat
  `ESS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_word_index) && $stable(out_word_value) && $stable(out_last), "stalled beat changed")

endmodule

bind encoder_sample_statistics ess_checker u_ess_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_word_index (out_ch.word_index),
  .out_word_value (out_ch.word_value),
  .out_last       (out_ch.last)
);

>>> bench/encoder_sample_statistics_tb.sv
`timescale 1ns / 1ps
module encoder_sample_statistics_tb;
  import ess_pkg::*;

  localparam logic [1:0]         CMD_UNUSED = 2'd3;
  localparam logic [31:0]        COUNT_FULL = 32'hFFFFFFFF;
  localparam logic signed [63:0] MEAN_SUM_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] MEAN_SUM_MIN = -64'sd140737488355328;
  localparam logic signed [63:0] S64_TOP = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] S64_BOTTOM = 64'sh8000000000000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] raw;
    int          idle_pct;
    int          stall_pct;
    bit          drain_first;
  } sample_cmd_t;

  typedef struct {
    status_t            status;
    logic [3:0]         word_index;
    logic signed [63:0] word_value;
    logic               last;
  } stat_word_t;

  logic clk;
  logic rst_n;

  ess_in_if  in_ch ();
  ess_out_if out_ch ();

  encoder_sample_statistics dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_cmd_t pending_cmds[$];
  stat_word_t  expected_words[$];
  int          fail_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        in_fire = 1'b0;

  // Shadow statistics
  bit                 sh_started;
  logic [31:0]        sh_count;
  logic [15:0]        sh_first;
  logic [15:0]        sh_last;
  logic signed [63:0] sh_unwrapped;
  logic signed [63:0] sh_min;
  logic signed [63:0] sh_max;
  logic signed [63:0] sh_sum;
  logic signed [63:0] sh_sumsq;
  logic [15:0]        sh_max_step;
  logic [31:0]        sh_crc;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit add_ovf(logic signed [63:0] a, logic signed [63:0] b,
                                 output logic signed [63:0] r);
    r = a + b;
    return (a[63] == b[63]) && (r[63] != a[63]);
  endfunction

  function automatic bit sub_ovf(logic signed [63:0] a, logic signed [63:0] b,
                                 output logic signed [63:0] r);
    r = a - b;
    return (a[63] != b[63]) && (r[63] != a[63]);
  endfunction

  // Reflected CRC-32 over one sample, low byte first
  function automatic logic [31:0] crc_sample(logic [31:0] c, logic [15:0] w);
    c ^= {24'd0, w[7:0]};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    c ^= {24'd0, w[15:8]};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Q16 mean, rounded half away from zero; returns 1 when it cannot be formed
  function automatic bit mean_fails(logic signed [63:0] sum, logic [31:0] cnt,
                                    output logic signed [63:0] r);
    logic signed [63:0] scaled;
    logic signed [63:0] half;
    logic signed [63:0] divisor;
    logic [63:0]        mag;
    r = '0;
    if (cnt == 0 || sum > MEAN_SUM_MAX || sum < MEAN_SUM_MIN) return 1'b1;
    scaled = sum <<< Q16_SHIFT;
    half = {33'd0, cnt[31:1]};
    divisor = {32'd0, cnt};
    if (!scaled[63]) begin
      if (scaled > S64_TOP - half) return 1'b1;
      r = (scaled + half) / divisor;
      return 1'b0;
    end
    if (scaled == S64_BOTTOM) return 1'b1;
    mag = -scaled;
    if (mag > 64'(S64_TOP - half)) return 1'b1;
    r = -signed'(64'((mag + 64'(half)) / 64'(divisor)));
    return 1'b0;
  endfunction

  function automatic void clear_stats();
    sh_started = 1'b0;
    sh_count = '0;
    sh_first = '0;
    sh_last = '0;
    sh_unwrapped = '0;
    sh_min = '0;
    sh_max = '0;
    sh_sum = '0;
    sh_sumsq = '0;
    sh_max_step = '0;
    sh_crc = CRC_INIT;
  endfunction

  function automatic void expect_word(status_t st, logic [3:0] idx,
                                      logic signed [63:0] v, logic lst);
    stat_word_t w;
    w.status = st;
    w.word_index = idx;
    w.word_value = v;
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  function automatic void push_sample(logic [15:0] raw);
    logic signed [31:0] delta;
    logic signed [63:0] nu, rel, ns, sq, nsq;
    logic [31:0]        ab;
    if (sh_count >= COUNT_FULL) begin
      expect_word(ST_REJECT, WORD_COUNT, '0, 1'b1);
      return;
    end
    if (!sh_started) begin
      sh_started = 1'b1;
      sh_count = 1;
      sh_first = raw;
      sh_last = raw;
      sh_unwrapped = {48'd0, raw};
      sh_min = '0;
      sh_max = '0;
      sh_sum = '0;
      sh_sumsq = '0;
      sh_max_step = '0;
      sh_crc = crc_sample(sh_crc, raw);
      expect_word(ST_OK, WORD_COUNT, '0, 1'b1);
      return;
    end
    delta = signed'({16'd0, raw}) - signed'({16'd0, sh_last});
    if (delta > 32767) delta -= 65536;
    else if (delta < -32768) delta += 65536;
    if (add_ovf(sh_unwrapped, 64'(delta), nu) ||
        sub_ovf(nu, {48'd0, sh_first}, rel) ||
        add_ovf(sh_sum, rel, ns) ||
        rel > SQUARE_LIMIT || rel < NEG_SQUARE_LIMIT) begin
      expect_word(ST_REJECT, WORD_COUNT, '0, 1'b1);
      return;
    end
    sq = rel * rel;
    if (add_ovf(sh_sumsq, sq, nsq)) begin
      expect_word(ST_REJECT, WORD_COUNT, '0, 1'b1);
      return;
    end
    ab = delta[31] ? 32'(-delta) : 32'(delta);
    sh_count++;
    sh_last = raw;
    sh_unwrapped = nu;
    if (rel < sh_min) sh_min = rel;
    if (rel > sh_max) sh_max = rel;
    sh_sum = ns;
    sh_sumsq = nsq;
    if (ab > {16'd0, sh_max_step}) sh_max_step = ab[15:0];
    sh_crc = crc_sample(sh_crc, raw);
    expect_word(ST_OK, WORD_COUNT, '0, 1'b1);
  endfunction

  function automatic void report_stats();
    logic signed [63:0] p2p, drift, mean;
    if (!sh_started || sh_count == 0 ||
        sub_ovf(sh_max, sh_min, p2p) ||
        sub_ovf(sh_unwrapped, {48'd0, sh_first}, drift) ||
        mean_fails(sh_sum, sh_count, mean)) begin
      expect_word(ST_FAIL, WORD_COUNT, '0, 1'b1);
      return;
    end
    expect_word(ST_OK, WORD_COUNT, {32'd0, sh_count}, 1'b0);
    expect_word(ST_OK, WORD_FIRST, {48'd0, sh_first}, 1'b0);
    expect_word(ST_OK, WORD_LAST, {48'd0, sh_last}, 1'b0);
    expect_word(ST_OK, WORD_MIN, sh_min, 1'b0);
    expect_word(ST_OK, WORD_MAX, sh_max, 1'b0);
    expect_word(ST_OK, WORD_SUM, sh_sum, 1'b0);
    expect_word(ST_OK, WORD_SUMSQ, sh_sumsq, 1'b0);
    expect_word(ST_OK, WORD_MAXSTEP, {48'd0, sh_max_step}, 1'b0);
    expect_word(ST_OK, WORD_CRC, {32'd0, sh_crc ^ CRC_INIT}, 1'b0);
    expect_word(ST_OK, WORD_P2P, p2p, 1'b0);
    expect_word(ST_OK, WORD_DRIFT, drift, 1'b0);
    expect_word(ST_OK, WORD_MEAN, mean, 1'b1);
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic [15:0] raw);
    case (cmd)
      CMD_PUSH: push_sample(raw);
      CMD_CLEAR: begin
        clear_stats();
        expect_word(ST_OK, WORD_COUNT, '0, 1'b1);
      end
      CMD_REPORT: report_stats();
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, logic [15:0] raw, int idle,
                                    int stall, bit drain = 1'b0);
    sample_cmd_t c;
    c.cmd = cmd;
    c.raw = raw;
    c.idle_pct = idle;
    c.stall_pct = stall;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endfunction

  // Random walk of pushes, closed by a report most of the time
  task automatic queue_run(int idle, int stall);
    int          n;
    logic [15:0] raw;
    n = $urandom_range(20, 2);
    raw = 16'($urandom);
    if ($urandom_range(99) < 30) queue_cmd(CMD_CLEAR, 16'($urandom), idle, stall);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: raw = 16'($urandom);
        1: raw = raw + 16'($urandom_range(32768, 32767));
        default: raw = raw + 16'($urandom_range(200)) - 16'd100;
      endcase
      queue_cmd(CMD_PUSH, raw, idle, stall);
    end
    if ($urandom_range(99) < 85) queue_cmd(CMD_REPORT, 16'($urandom), idle, stall);
    if ($urandom_range(99) < 8) queue_cmd(CMD_UNUSED, 16'($urandom), idle, stall);
  endtask

  // Latch acceptance and predict on each input beat
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) apply_command(in_ch.cmd, in_ch.raw_sample);
  end

  // Drive input beats at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_cmds.size() == 0 ||
          (pending_cmds[0].drain_first && (expected_words.size() != 0 || in_ch.valid))) begin
        in_ch.valid <= 1'b0;
      end else if ($urandom_range(99) < pending_cmds[0].idle_pct) begin
        in_ch.valid <= 1'b0;
      end else begin
        idle_pct = pending_cmds[0].idle_pct;
        stall_pct = pending_cmds[0].stall_pct;
        in_ch.cmd <= pending_cmds[0].cmd;
        in_ch.raw_sample <= pending_cmds[0].raw;
        in_ch.valid <= 1'b1;
        void'(pending_cmds.pop_front());
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    stat_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result beat: status %0d word %0d value %0d",
               out_ch.status, out_ch.word_index, out_ch.word_value);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_ch.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.word_index !== w.word_index) begin
          $error("word_index: expected %0d, got %0d", w.word_index, out_ch.word_index);
          fail_count++;
        end
        if (out_ch.word_value !== w.word_value) begin
          $error("word_value: expected %0d, got %0d", w.word_value, out_ch.word_value);
          fail_count++;
        end
        if (out_ch.last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 70, 0, 7};
    stall_set = '{0, 0, 70, 7};
    clear_stats();
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PUSH;
    in_ch.raw_sample = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty report, wrap-around steps, extremes, unused command
    queue_cmd(CMD_REPORT, 16'h0000, 0, 0);
    queue_cmd(CMD_UNUSED, 16'hFFFF, 0, 0);
    queue_cmd(CMD_PUSH, 16'h0000, 0, 0);
    queue_cmd(CMD_REPORT, 16'h0000, 0, 0);
    queue_cmd(CMD_PUSH, 16'hFFFF, 0, 0);
    queue_cmd(CMD_PUSH, 16'h7FFF, 0, 0);
    queue_cmd(CMD_PUSH, 16'hFFFF, 0, 0);
    queue_cmd(CMD_PUSH, 16'h8000, 0, 0);
    queue_cmd(CMD_PUSH, 16'h0000, 0, 0);
    queue_cmd(CMD_PUSH, 16'h7FFF, 0, 0);
    queue_cmd(CMD_REPORT, 16'hFFFF, 0, 0);
    queue_cmd(CMD_CLEAR, 16'h0000, 0, 0);
    queue_cmd(CMD_REPORT, 16'h0000, 0, 0);
    queue_cmd(CMD_PUSH, 16'h8000, 0, 0);
    queue_cmd(CMD_PUSH, 16'h0001, 0, 0);
    queue_cmd(CMD_PUSH, 16'hFFFE, 0, 0);
    queue_cmd(CMD_PUSH, 16'h8001, 0, 0);
    queue_cmd(CMD_REPORT, 16'h0000, 0, 0);
    queue_cmd(CMD_UNUSED, 16'h0000, 0, 0);
    queue_cmd(CMD_CLEAR, 16'hFFFF, 0, 0, 1'b1);
    queue_cmd(CMD_PUSH, 16'h1234, 0, 0);
    queue_cmd(CMD_REPORT, 16'h0000, 0, 0);

    // Random runs across the idle and stall phases, with a full drain between phases
    for (int p = 0; p < 4; p++) begin
      while (pending_cmds.size() < 22 + (p + 1) * 105) queue_run(idle_set[p], stall_set[p]);
      queue_cmd(CMD_REPORT, 16'($urandom), idle_set[p], stall_set[p], 1'b1);
    end

    wait (pending_cmds.size() == 0 && !in_ch.valid && expected_words.size() == 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ess_pkg.sv
rtl/ess_if.sv
rtl/ess_alu.sv
rtl/ess_crc.sv
rtl/encoder_sample_statistics.sv
rtl/ess_checker.sv
bench/encoder_sample_statistics_tb.sv
